/* rtl/trp_pkg.sv */
// ----------------------------------------------------------------------------
// trp_pkg
// Shared widths, opcodes, character constants and helpers for the trie root
// prefix replacer.
// ----------------------------------------------------------------------------
package trp_pkg;

	localparam int OPCODE_W = 3;
	localparam int CHAR_W   = 7;
	localparam int LETTERS  = 26;
	localparam int LETTER_W = 5;
	// node word: {end mark, child valid bitmap}
	localparam int NODE_W   = LETTERS + 1;

	localparam logic [OPCODE_W-1:0] OP_INSERT_CHAR  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_END_ROOT     = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_SENTENCE_CHR = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_END_SENTENCE = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_CLEAR_DICT   = 3'd4;

	localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

	localparam logic [1:0] MODE_MATCH = 2'd0;
	localparam logic [1:0] MODE_COPY  = 2'd1;
	localparam logic [1:0] MODE_DROP  = 2'd2;

	typedef logic [LETTERS-1:0] valid_map_t;

	function automatic logic is_letter(input logic [CHAR_W-1:0] c);
		return (c >= CHAR_A) && (c < CHAR_A + CHAR_W'(LETTERS));
	endfunction

	function automatic logic [LETTER_W-1:0] letter_index(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		d = c - CHAR_A;
		return d[LETTER_W-1:0];
	endfunction

endpackage

/* rtl/trp_cmd_if.sv */
// ----------------------------------------------------------------------------
// trp_cmd_if
// Command channel: opcode and character, valid/ready handshake.
// ----------------------------------------------------------------------------
interface trp_cmd_if;
	import trp_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [CHAR_W-1:0]   char_in;

	modport source (output valid, output opcode, output char_in, input ready);
	modport sink   (input valid, input opcode, input char_in, output ready);
endinterface

/* rtl/trp_res_if.sv */
// ----------------------------------------------------------------------------
// trp_res_if
// Result channel: emitted character and flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface trp_res_if;
	import trp_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_out;
	logic              end_of_sentence;
	logic              dictionary_full;

	modport source (output valid, output char_out, output end_of_sentence,
		output dictionary_full, input ready);
	modport sink   (input valid, input char_out, input end_of_sentence,
		input dictionary_full, output ready);
endinterface

/* rtl/trie_root_prefix_replacer_top.sv */
// ----------------------------------------------------------------------------
// trie_root_prefix_replacer_top
// Shortest-root word replacer over a 26-way trie held in node memories.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one transaction per item: opcode (insert root char, end root,
//   sentence char, end sentence, clear) and char_in. res carries emitted
//   characters; the end of a sentence gives one transaction with
//   end_of_sentence set and char_out zero. dictionary_full is sticky until a
//   clear and rides on every result.
//   Items are processed one at a time. cmd.ready is high only while the
//   control is idle. Each accepted item goes from idle to an evaluate step on
//   the node word read at accept from the registered-read memories; a sentence
//   letter that walks the trie then takes the child-pointer read, the child
//   node read (end-mark step) and the output step; a copied or dropped sentence
//   character and an end of sentence go to the output step; a root letter goes
//   on to the pointer or node-init step unless skipped; end root and clear return to idle.
//   Results go through one output register; while it is full and res.ready is
//   low, the control holds in its output step, and cmd stays blocked.
//   Reset (arst_n low) empties the dictionary and returns both cursors to the
//   root; the root entry sits in flip-flops, so no memory sweep is needed.
// ----------------------------------------------------------------------------
module trie_root_prefix_replacer_top #(
	parameter int NODES = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	trp_cmd_if.sink   cmd,
	trp_res_if.source res
);
	import trp_pkg::*;

	localparam int NW     = $clog2(NODES);
	localparam int UW     = NW + 1;
	localparam int PDEPTH = NODES * LETTERS;
	localparam int PW     = $clog2(PDEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_PTR  = 3'd2;
	localparam logic [2:0] ST_END  = 3'd3;
	localparam logic [2:0] ST_INIT = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]          state_q;
	logic [OPCODE_W-1:0] op_q;
	logic [CHAR_W-1:0]   ch_q;
	logic [NW-1:0]       insert_cursor_q;
	logic [NW-1:0]       match_cursor_q;
	logic [UW-1:0]       nodes_used_q;
	logic [1:0]          mode_q;
	logic                space_pending_q;
	logic                overflow_q;
	logic                dropped_q;
	valid_map_t          root_valid_q;
	logic                root_end_q;
	logic                rd_root_q;
	logic                emit_sp_q;
	logic                emit_ch_q;
	logic                eos_q;
	logic                res_valid_q;
	logic [CHAR_W-1:0]   res_char_q;
	logic                res_eos_q;
	logic                res_full_q;

	// memory ports
	logic              node_we;
	logic [NW-1:0]     node_waddr;
	logic [NODE_W-1:0] node_wdata;
	logic [NW-1:0]     node_raddr;
	logic [NODE_W-1:0] node_rdata;
	logic              ptr_we;
	logic [PW-1:0]     ptr_waddr;
	logic [NW-1:0]     ptr_wdata;
	logic [PW-1:0]     ptr_raddr;
	logic [NW-1:0]     ptr_rdata;

	logic [NODE_W-1:0]   node_word;
	valid_map_t          cur_valid;
	logic                cur_end;
	logic [LETTER_W-1:0] lidx;
	valid_map_t          lbit;
	logic                letter;
	logic [NW-1:0]       cursor;
	logic                slot_free;

	trp_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	trp_ram #(.DEPTH(PDEPTH), .WIDTH(NW)) u_ptr_ram (
		.clk   (clk),
		.we    (ptr_we),
		.waddr (ptr_waddr),
		.wdata (ptr_wdata),
		.raddr (ptr_raddr),
		.rdata (ptr_rdata)
	);

	// decode the held item; the root entry overrides the node memory
	assign node_word = rd_root_q ? {root_end_q, root_valid_q} : node_rdata;
	assign cur_valid = node_word[LETTERS-1:0];
	assign cur_end   = node_word[LETTERS];
	assign lidx      = letter_index(ch_q);
	assign lbit      = valid_map_t'(1) << lidx;
	assign letter    = is_letter(ch_q);
	assign cursor    = (op_q == OP_INSERT_CHAR) ? insert_cursor_q : match_cursor_q;
	assign slot_free = !res_valid_q || res.ready;
	assign ptr_raddr = PW'(cursor) * PW'(LETTERS) + PW'(lidx);

	// node read address: current cursor at accept, child node after pointer read
	always_comb begin
		node_raddr = match_cursor_q;
		if (state_q == ST_IDLE) begin
			node_raddr = (cmd.opcode == OP_INSERT_CHAR || cmd.opcode == OP_END_ROOT)
				? insert_cursor_q : match_cursor_q;
		end else if (state_q == ST_PTR) begin
			node_raddr = ptr_rdata;
		end
	end

	// memory writes: link a new child, extend a bitmap, set an end mark, init a node
	always_comb begin
		node_we    = 1'b0;
		node_waddr = insert_cursor_q;
		node_wdata = {cur_end, cur_valid | lbit};
		ptr_we     = 1'b0;
		ptr_waddr  = ptr_raddr;
		ptr_wdata  = nodes_used_q[NW-1:0];
		case (state_q)
			ST_EVAL: begin
				if (op_q == OP_INSERT_CHAR && !dropped_q && letter && !cur_valid[lidx]
						&& nodes_used_q < UW'(NODES)) begin
					ptr_we  = 1'b1;
					node_we = (insert_cursor_q != '0);
				end else if (op_q == OP_END_ROOT && !dropped_q) begin
					node_we    = (insert_cursor_q != '0);
					node_wdata = {1'b1, cur_valid};
				end
			end
			ST_INIT: begin
				node_we    = 1'b1;
				node_wdata = '0;
			end
			default: begin
			end
		endcase
	end

	// remember whether the issued node read targets the root entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_root_q <= 1'b1;
		end else begin
			rd_root_q <= (node_raddr == '0);
		end
	end

	// hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q <= cmd.opcode;
			ch_q <= cmd.char_in;
		end
	end

	assign cmd.ready = (state_q == ST_IDLE);

	// control sequencer and trie state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			insert_cursor_q <= '0;
			match_cursor_q  <= '0;
			nodes_used_q    <= UW'(1);
			mode_q          <= MODE_MATCH;
			space_pending_q <= 1'b0;
			overflow_q      <= 1'b0;
			dropped_q       <= 1'b0;
			root_valid_q    <= '0;
			root_end_q      <= 1'b0;
			emit_sp_q       <= 1'b0;
			emit_ch_q       <= 1'b0;
			eos_q           <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_IDLE;
					case (op_q)
						OP_INSERT_CHAR: begin
							if (!dropped_q && letter) begin
								if (cur_valid[lidx]) begin
									state_q <= ST_PTR;
								end else if (nodes_used_q < UW'(NODES)) begin
									if (insert_cursor_q == '0) begin
										root_valid_q <= root_valid_q | lbit;
									end
									insert_cursor_q <= nodes_used_q[NW-1:0];
									nodes_used_q    <= nodes_used_q + UW'(1);
									state_q         <= ST_INIT;
								end else begin
									overflow_q <= 1'b1;
									dropped_q  <= 1'b1;
								end
							end
						end
						OP_END_ROOT: begin
							if (!dropped_q && insert_cursor_q == '0) begin
								root_end_q <= 1'b1;
							end
							insert_cursor_q <= '0;
							dropped_q       <= 1'b0;
						end
						OP_SENTENCE_CHR: begin
							state_q   <= ST_OUT;
							emit_sp_q <= space_pending_q;
							eos_q     <= 1'b0;
							if (ch_q == CHAR_SPACE) begin
								space_pending_q <= 1'b1;
								match_cursor_q  <= '0;
								mode_q          <= MODE_MATCH;
							end else begin
								space_pending_q <= 1'b0;
								if (mode_q == MODE_COPY) begin
									emit_ch_q <= 1'b1;
								end else if (mode_q == MODE_MATCH) begin
									if (letter && cur_valid[lidx]) begin
										state_q <= ST_PTR;
									end else begin
										mode_q    <= MODE_COPY;
										emit_ch_q <= 1'b1;
									end
								end
							end
						end
						OP_END_SENTENCE: begin
							space_pending_q <= 1'b0;
							match_cursor_q  <= '0;
							mode_q          <= MODE_MATCH;
							emit_ch_q       <= 1'b1;
							eos_q           <= 1'b1;
							state_q         <= ST_OUT;
						end
						OP_CLEAR_DICT: begin
							root_valid_q    <= '0;
							root_end_q      <= 1'b0;
							nodes_used_q    <= UW'(1);
							insert_cursor_q <= '0;
							dropped_q       <= 1'b0;
							overflow_q      <= 1'b0;
							if (match_cursor_q != '0 && mode_q == MODE_MATCH) begin
								mode_q <= MODE_COPY;
							end
							match_cursor_q <= '0;
						end
						default: begin
						end
					endcase
				end
				ST_PTR: begin
					// advance the cursor along the stored child pointer
					if (op_q == OP_INSERT_CHAR) begin
						insert_cursor_q <= ptr_rdata;
						state_q         <= ST_IDLE;
					end else begin
						match_cursor_q <= ptr_rdata;
						state_q        <= ST_END;
					end
				end
				ST_END: begin
					if (cur_end) begin
						mode_q <= MODE_DROP;
					end
					emit_ch_q <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_INIT: begin
					state_q <= ST_IDLE;
				end
				ST_OUT: begin
					// held space first, then the character or end marker
					if (emit_sp_q) begin
						if (slot_free) begin
							emit_sp_q <= 1'b0;
						end
					end else if (emit_ch_q) begin
						if (slot_free) begin
							emit_ch_q <= 1'b0;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (emit_sp_q || emit_ch_q) && slot_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (emit_sp_q || emit_ch_q) && slot_free) begin
			res_char_q <= emit_sp_q ? CHAR_SPACE : (eos_q ? '0 : ch_q);
			res_eos_q  <= !emit_sp_q && eos_q;
			res_full_q <= overflow_q;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.char_out        = res_char_q;
	assign res.end_of_sentence = res_eos_q;
	assign res.dictionary_full = res_full_q;
endmodule

/* rtl/trp_ram.sv */
// ----------------------------------------------------------------------------
// trp_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module trp_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

/* rtl/trp_checker.sv */
// ----------------------------------------------------------------------------
// trp_checker
// Port-level checks for the trie root prefix replacer, bound to the top.
// ----------------------------------------------------------------------------
module trp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cmd_valid,
	input logic                      cmd_ready,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [trp_pkg::CHAR_W-1:0] res_char_out,
	input logic                      res_end_of_sentence,
	input logic                      res_dictionary_full
);
	import trp_pkg::*;

	// one item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted in back-to-back cycles");

	// the end marker carries no character
	a_eos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_end_of_sentence |-> res_char_out == '0)
		else $error("end-of-sentence result with nonzero character");

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// a stalled result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_char_out)
			&& $stable(res_end_of_sentence) && $stable(res_dictionary_full))
		else $error("result payload changed while stalled");
endmodule

bind trie_root_prefix_replacer_top trp_checker u_trp_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.cmd_valid           (cmd.valid),
	.cmd_ready           (cmd.ready),
	.res_valid           (res.valid),
	.res_ready           (res.ready),
	.res_char_out        (res.char_out),
	.res_end_of_sentence (res.end_of_sentence),
	.res_dictionary_full (res.dictionary_full)
);

/* dv/trie_root_prefix_replacer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trie_root_prefix_replacer_checker
// Watches the command and result channels, keeps a software trie of the root
// words, works out the characters each accepted command must produce and
// compares every accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
module trie_root_prefix_replacer_checker #(
	parameter int NODES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	trp_cmd_if   cmd,
	trp_res_if   res,
	output int   outstanding,
	output int   mismatches
);
	import trp_pkg::*;

	localparam int PTR_W = $clog2(NODES);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              eos;
		logic              full;
	} out_char_t;

	// software trie
	logic [PTR_W-1:0] child_ptr [NODES*LETTERS];
	valid_map_t       child_map [NODES];
	logic             end_mark  [NODES];
	int               nodes_taken;
	logic [PTR_W-1:0] insert_at;
	logic             root_lost;
	logic             pool_full;

	// sentence walk
	logic [PTR_W-1:0] walk_at;
	logic [1:0]       word_state;
	logic             space_held;

	out_char_t        owed_chars [$];
	int               fail_count;

	function automatic logic lower_case(input logic [CHAR_W-1:0] c);
		return (c >= CHAR_A) && (c <= CHAR_A + CHAR_W'(LETTERS - 1));
	endfunction

	function automatic void owe_char(input logic [CHAR_W-1:0] c, input logic eos);
		out_char_t item;
		item.ch   = c;
		item.eos  = eos;
		item.full = pool_full;
		owed_chars.insert(owed_chars.size(), item);
	endfunction

	// Empty the trie down to a bare root and drop the sticky flag.
	function automatic void empty_dictionary();
		child_map[0] = '0;
		end_mark[0]  = 1'b0;
		nodes_taken  = 1;
		insert_at    = '0;
		root_lost    = 1'b0;
		pool_full    = 1'b0;
	endfunction

	// Extend the root being inserted by one character.
	function automatic void grow_root(input logic [CHAR_W-1:0] c);
		int l;
		if (root_lost || !lower_case(c))
			return;
		l = int'(c) - int'(CHAR_A);
		if (child_map[insert_at][l]) begin
			insert_at = child_ptr[int'(insert_at) * LETTERS + l];
		end else if (nodes_taken < NODES) begin
			child_map[nodes_taken] = '0;
			end_mark[nodes_taken]  = 1'b0;
			child_ptr[int'(insert_at) * LETTERS + l] = PTR_W'(nodes_taken);
			child_map[insert_at][l] = 1'b1;
			insert_at = PTR_W'(nodes_taken);
			nodes_taken++;
		end else begin
			pool_full = 1'b1;
			root_lost = 1'b1;
		end
	endfunction

	// Walk one sentence character; a space is held back until the next one.
	function automatic void walk_sentence(input logic [CHAR_W-1:0] c);
		int l;
		if (c == CHAR_SPACE) begin
			if (space_held)
				owe_char(CHAR_SPACE, 1'b0);
			space_held = 1'b1;
			walk_at    = '0;
			word_state = MODE_MATCH;
			return;
		end
		if (space_held) begin
			owe_char(CHAR_SPACE, 1'b0);
			space_held = 1'b0;
		end
		if (word_state == MODE_DROP)
			return;
		if (word_state == MODE_MATCH) begin
			l = int'(c) - int'(CHAR_A);
			if (lower_case(c) && child_map[walk_at][l]) begin
				walk_at = child_ptr[int'(walk_at) * LETTERS + l];
				if (end_mark[walk_at])
					word_state = MODE_DROP;
			end else begin
				word_state = MODE_COPY;
			end
		end
		owe_char(c, 1'b0);
	endfunction

	function automatic void predict(input logic [OPCODE_W-1:0] op,
		input logic [CHAR_W-1:0] c);
		case (op)
			OP_INSERT_CHAR: grow_root(c);
			OP_END_ROOT: begin
				if (!root_lost)
					end_mark[insert_at] = 1'b1;
				insert_at = '0;
				root_lost = 1'b0;
			end
			OP_SENTENCE_CHR: walk_sentence(c);
			OP_END_SENTENCE: begin
				space_held = 1'b0;
				walk_at    = '0;
				word_state = MODE_MATCH;
				owe_char('0, 1'b1);
			end
			OP_CLEAR_DICT: begin
				empty_dictionary();
				if (walk_at != '0 && word_state == MODE_MATCH)
					word_state = MODE_COPY;
				walk_at = '0;
			end
			default: ;
		endcase
	endfunction

	function automatic void flag_result(input logic owed, input out_char_t want,
		input out_char_t got);
		fail_count++;
		if (fail_count <= 10) begin
			if (owed)
				$display("[%0t] mismatch: want %02h/%0b/%0b got %02h/%0b/%0b (char/eos/full)",
					$time, want.ch, want.eos, want.full, got.ch, got.eos, got.full);
			else
				$display("[%0t] unexpected result: char 0x%02h eos %0b full %0b",
					$time, got.ch, got.eos, got.full);
		end
	endfunction

	// Predict on each command transaction, compare on each result transaction.
	always @(posedge clk or negedge arst_n) begin : watch
		out_char_t want;
		out_char_t got;
		if (!arst_n) begin
			empty_dictionary();
			walk_at    = '0;
			word_state = MODE_MATCH;
			space_held = 1'b0;
			owed_chars.delete();
			fail_count = 0;
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (cmd.valid && cmd.ready)
				predict(cmd.opcode, cmd.char_in);
			if (res.valid && res.ready) begin
				got = '{ch: res.char_out, eos: res.end_of_sentence, full: res.dictionary_full};
				if (owed_chars.size() == 0) begin
					flag_result(1'b0, '0, got);
				end else begin
					want = owed_chars.pop_front();
					if (got.ch !== want.ch || got.eos !== want.eos || got.full !== want.full)
						flag_result(1'b1, want, got);
				end
			end
			outstanding <= owed_chars.size();
			mismatches  <= fail_count;
		end
	end

endmodule

/* dv/trie_root_prefix_replacer_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trie_root_prefix_replacer_top_test
// Drives root inserts, sentences and clears into the replacer: a directed
// opening, a back-pressure stretch, a pool-exhaustion run, then random
// dictionaries and sentences under four idle/stall mixes. A checker beside
// the block predicts and compares; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module trie_root_prefix_replacer_top_test;
	import trp_pkg::*;

	localparam int NODES         = 1024;
	localparam int RANDOM_ITEMS  = 600;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_ROOTS     = 16;
	localparam int MAX_ROOT_LEN  = 8;
	localparam logic [OPCODE_W-1:0] OP_FIRST_UNUSED = 3'd5;

	logic clk = 1'b0;
	logic arst_n;

	trp_cmd_if cmd ();
	trp_res_if res ();

	int   outstanding;
	int   mismatches;
	int   cycle_count = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   sent_count = 0;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left = 0;

	// roots known to be in the dictionary, used to build matching words
	logic [CHAR_W-1:0] root_txt [MAX_ROOTS][MAX_ROOT_LEN];
	int                root_len [MAX_ROOTS];
	int                root_count = 0;

	trie_root_prefix_replacer_top #(.NODES(NODES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	trie_root_prefix_replacer_checker #(.NODES(NODES)) replace_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.res         (res),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always #5 clk = ~clk;

	// Stall the result side at random; hold it off once for a long stretch.
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// End the run if it hangs.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** trie_root_prefix_replacer_top: FAILED **");
		$finish;
	end

	function automatic logic [CHAR_W-1:0] ltr(input int i);
		return CHAR_A + CHAR_W'(i);
	endfunction

	function automatic logic [CHAR_W-1:0] noise_char();
		if ($urandom_range(1))
			return CHAR_W'($urandom_range(96));
		return CHAR_W'($urandom_range(127, 123));
	endfunction

	// Offer one transaction, wait for it to be taken, then maybe go idle.
	task automatic send(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] c);
		cmd.valid   <= 1'b1;
		cmd.opcode  <= op;
		cmd.char_in <= c;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		if (op <= OP_CLEAR_DICT)
			sent_count++;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic pause_until_drained();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic clear_dictionary();
		send(OP_CLEAR_DICT, CHAR_W'($urandom));
		root_count = 0;
	endtask

	// Insert a random root, with stray non-letters now and then; remember it.
	task automatic add_random_root(input int len, input int span);
		int                slot;
		logic [CHAR_W-1:0] c;
		slot = root_count;
		for (int i = 0; i < len; i++) begin
			c = ltr($urandom_range(span - 1));
			if (slot < MAX_ROOTS)
				root_txt[slot][i] = c;
			send(OP_INSERT_CHAR, c);
			if ($urandom_range(19) == 0)
				send(OP_INSERT_CHAR, noise_char());
		end
		send(OP_END_ROOT, CHAR_W'($urandom));
		if (slot < MAX_ROOTS) begin
			root_len[slot] = len;
			root_count++;
		end
	endtask

	// Send a sentence character, sometimes followed by a clear, an unused
	// opcode or a short root insert.
	task automatic say(input logic [CHAR_W-1:0] c);
		send(OP_SENTENCE_CHR, c);
		case ($urandom_range(59))
			0: clear_dictionary();
			1: send(OP_FIRST_UNUSED + OPCODE_W'($urandom_range(2)), CHAR_W'($urandom));
			2: add_random_root($urandom_range(1, 3), 5);
			default: ;
		endcase
	endtask

	// Build a word: a stored root with a tail, a cut root, or random letters.
	task automatic send_word();
		int kind;
		int r;
		int n;
		int tail;
		kind = $urandom_range(3);
		if (kind <= 1 && root_count > 0) begin
			r = $urandom_range(root_count - 1);
			n = (kind == 0) ? root_len[r] : $urandom_range(root_len[r]);
			tail = $urandom_range(3);
			for (int i = 0; i < n; i++)
				say(root_txt[r][i]);
			for (int i = 0; i < tail; i++)
				say(ltr($urandom_range(4)));
		end else begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				if (kind == 3 && $urandom_range(4) == 0)
					say(noise_char());
				else
					say(ltr($urandom_range(kind == 2 ? 4 : LETTERS - 1)));
			end
		end
	endtask

	task automatic send_sentence();
		int words;
		int gap;
		words = $urandom_range(5);
		if ($urandom_range(7) == 0)
			say(CHAR_SPACE);
		for (int w = 0; w < words; w++) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
			if (w > 0)
				repeat (gap) say(CHAR_SPACE);
			send_word();
		end
		if ($urandom_range(1))
			say(CHAR_SPACE);
		send(OP_END_SENTENCE, CHAR_W'($urandom));
	endtask

	task automatic random_session();
		int roots;
		int sentences;
		if ($urandom_range(1) == 0 || root_count >= MAX_ROOTS)
			clear_dictionary();
		roots = $urandom_range(1, 4);
		repeat (roots)
			add_random_root(($urandom_range(19) == 0) ? 0 : $urandom_range(1, 5),
				($urandom_range(4) == 0) ? LETTERS : 5);
		sentences = $urandom_range(1, 3);
		repeat (sentences)
			send_sentence();
	endtask

	initial begin : stimulus
		arst_n      <= 1'b0;
		cmd.valid   <= 1'b0;
		cmd.opcode  <= OP_INSERT_CHAR;
		cmd.char_in <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: roots "cat", "be" with a stray '#', and an empty root
		send(OP_CLEAR_DICT, 7'h7f);
		send(OP_INSERT_CHAR, ltr(2));
		send(OP_INSERT_CHAR, ltr(0));
		send(OP_INSERT_CHAR, ltr(19));
		send(OP_END_ROOT, '0);
		send(OP_INSERT_CHAR, ltr(1));
		send(OP_INSERT_CHAR, 7'h23);
		send(OP_INSERT_CHAR, ltr(4));
		send(OP_END_ROOT, 7'h7f);
		send(OP_INSERT_CHAR, 7'h60);
		send(OP_INSERT_CHAR, 7'h7b);
		send(OP_END_ROOT, '0);
		// "cats  bee ": drop after a root, keep the double space, strip the last
		send(OP_SENTENCE_CHR, ltr(2));
		send(OP_SENTENCE_CHR, ltr(0));
		send(OP_SENTENCE_CHR, ltr(19));
		send(OP_SENTENCE_CHR, ltr(18));
		send(OP_SENTENCE_CHR, CHAR_SPACE);
		send(OP_SENTENCE_CHR, CHAR_SPACE);
		send(OP_SENTENCE_CHR, ltr(1));
		send(OP_SENTENCE_CHR, ltr(4));
		send(OP_SENTENCE_CHR, ltr(4));
		send(OP_SENTENCE_CHR, CHAR_SPACE);
		send(OP_END_SENTENCE, '0);
		// clear partway into a word, then the character extremes
		send(OP_SENTENCE_CHR, ltr(2));
		send(OP_CLEAR_DICT, '0);
		send(OP_SENTENCE_CHR, ltr(0));
		send(OP_SENTENCE_CHR, 7'h7f);
		send(OP_SENTENCE_CHR, 7'h00);
		send(OP_END_SENTENCE, 7'h7f);
		send(OP_FIRST_UNUSED + OPCODE_W'(2), 7'h55);
		send(OP_END_SENTENCE, '0);

		// hold the result side off while sentences keep coming
		pause_until_drained();
		root_count = 0;
		add_random_root(2, 5);
		add_random_root(3, 5);
		hold_req <= 1'b1;
		repeat (6) send_sentence();

		// exhaust the node pool with long roots, then use what is left
		pause_until_drained();
		idle_pct = 14;
		stall_pct <= 14;
		clear_dictionary();
		add_random_root(2, 5);
		add_random_root(2, 5);
		repeat (18) begin
			send(OP_INSERT_CHAR, ltr(LETTERS - 1));
			repeat (63) send(OP_INSERT_CHAR, ltr($urandom_range(LETTERS - 1)));
			send(OP_END_ROOT, '0);
		end
		add_random_root(1, 5);
		repeat (4) send_sentence();

		// random dictionaries and sentences under each idle/stall mix
		for (int phase = 0; phase < 4; phase++) begin
			pause_until_drained();
			case (phase)
				0: begin idle_pct = 0;  stall_pct <= 0;  end
				1: begin idle_pct = 54; stall_pct <= 0;  end
				2: begin idle_pct = 0;  stall_pct <= 54; end
				default: begin idle_pct = 14; stall_pct <= 14; end
			endcase
			sent_count = 0;
			while (sent_count < RANDOM_ITEMS / 4)
				random_session();
		end

		pause_until_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("** trie_root_prefix_replacer_top: PASSED **");
		else
			$display("** trie_root_prefix_replacer_top: FAILED **");
		$finish;
	end

endmodule
